// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the partition allocator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FPFA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fpfa assertion failed");

// Same, on the block clock and reset.
`define FPFA_ASSERT_CLK(lbl, prop) \
    `FPFA_ASSERT(lbl, aclk, aresetn, prop)

`endif

// ===== hdl/fpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Partition allocator package
// Item types, codes and the command bundle shared by the core and its cells.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } fit_policy_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIT_POLICY    = 2'd0,
        REG_BLOCKS_IN_USE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot_index;
        logic [15:0] size_value;
        logic [7:0]  owner_id;
    } in_item_t;

    typedef struct packed {
        logic        granted;
        logic [4:0]  block_number;
        logic [15:0] space_left;
    } out_item_t;

    // Broadcast command from the core to every cell.
    typedef struct packed {
        logic       load;
        logic       clear;
        logic       grant;
        logic [7:0] owner;
    } cell_cmd_t;

endpackage

// ===== hdl/fpfa_cell.sv =====
// ----------------------------------------------------------------------------
// Partition cell
// Holds one partition and updates the travelling search record by one step.
// ----------------------------------------------------------------------------
module fpfa_cell import fpfa_pkg::*; #(
    parameter int CELL_IDX  = 0,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_cmd_t            cmd,
    input  logic                 load_hit,
    input  logic                 grant_hit,
    input  logic [SIZE_BITS-1:0] wr_size,
    input  logic [SIZE_BITS-1:0] req_size,
    input  logic [1:0]           policy,
    input  logic [4:0]           blocks_in_use,
    input  logic                 rin_valid,
    input  logic                 rin_found,
    input  logic [IDX_W-1:0]     rin_idx,
    input  logic [SIZE_BITS-1:0] rin_size,
    input  logic [SIZE_BITS-1:0] rin_left,
    output logic                 rout_valid_reg,
    output logic                 rout_found_reg,
    output logic [IDX_W-1:0]     rout_idx_reg,
    output logic [SIZE_BITS-1:0] rout_size_reg,
    output logic [SIZE_BITS-1:0] rout_left_reg
);

    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] free_reg;
    logic [7:0]           owner_reg;
    logic                 in_scope;
    logic                 eligible;
    logic                 take;

    assign in_scope = CELL_IDX < int'(blocks_in_use);
    assign eligible = rin_valid && in_scope && (owner_reg == 8'd0) && (size_reg >= req_size);

    always_comb begin
        unique case (policy)
            POL_BEST:  take = eligible && (!rin_found || size_reg <= rin_size);
            POL_WORST: take = eligible && (!rin_found || size_reg >= rin_size);
            default:   take = eligible && !rin_found;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg      <= 8'd0;
            rout_valid_reg <= 1'b0;
        end else begin
            rout_valid_reg <= rin_valid;
            if (load_hit || cmd.clear) begin
                owner_reg <= 8'd0;
            end else if (grant_hit) begin
                owner_reg <= cmd.owner;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_hit) begin
            size_reg <= wr_size;
            free_reg <= wr_size;
        end else if (cmd.clear) begin
            free_reg <= size_reg;
        end else if (grant_hit) begin
            free_reg <= wr_size;
        end
        rout_found_reg <= rin_found || take;
        rout_idx_reg   <= take ? IDX_W'(CELL_IDX) : rin_idx;
        rout_size_reg  <= take ? size_reg : rin_size;
        rout_left_reg  <= take ? (free_reg - req_size) : rin_left;
    end

endmodule

// ===== hdl/fixed_partition_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator core
// Partition table with first, best and worst fit allocation over a cell chain.
// ----------------------------------------------------------------------------
// The partition table lives in a row of MAX_PARTITIONS cells, one partition
// per cell. A load item writes one cell's size and frees it; a clear item
// frees every cell and restores each space left to its size; both then go
// straight to the push state. An allocate item sends a search record down
// the row through an inject register: each cell looks at the record in
// turn, one cell per clock, and replaces the current pick when its own
// partition is unowned, within blocks_in_use and large enough, following
// the fit policy. When the record leaves the last cell, the chosen cell is
// granted and the result is registered together; the push state then moves
// the result into the output register once that register is free, and the
// block returns to idle. One item is handled at a time; a new item is taken
// once the previous result has moved into the output register, even while
// that result still waits to be taken. An allocate with owner zero is
// refused at once. Configuration writes are always accepted and should
// only be made while the block is idle.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core import fpfa_pkg::*; #(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]           policy_reg;
    logic [4:0]           blocks_reg;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [7:0]           owner_reg, owner_next;
    logic                 inject_reg, inject_next;
    out_item_t            res_reg, res_next;
    out_item_t            m_data_reg, m_data_next;
    logic                 m_valid_reg, m_valid_next;

    // The search record travels along these links; index 0 feeds the first cell.
    logic                 link_valid [0:MAX_PARTITIONS];
    logic                 link_found [0:MAX_PARTITIONS];
    logic [IDX_W-1:0]     link_idx   [0:MAX_PARTITIONS];
    logic [SIZE_BITS-1:0] link_size  [0:MAX_PARTITIONS];
    logic [SIZE_BITS-1:0] link_left  [0:MAX_PARTITIONS];

    logic                 accept;
    logic                 scan_done;
    logic [SIZE_BITS-1:0] in_size;
    logic [SIZE_BITS-1:0] wr_size;
    cell_cmd_t            cmd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign in_size   = SIZE_BITS'(s_data.size_value);
    assign scan_done = (state_reg == ST_SCAN) && link_valid[MAX_PARTITIONS];

    // A load writes the incoming size; a grant writes the space left found in the scan.
    assign wr_size = (state_reg == ST_IDLE) ? in_size : link_left[MAX_PARTITIONS];

    always_comb begin
        cmd.load  = accept && (s_data.mode == MODE_LOAD);
        cmd.clear = accept && (s_data.mode == MODE_CLEAR);
        cmd.grant = scan_done && link_found[MAX_PARTITIONS];
        cmd.owner = owner_reg;
    end

    assign link_valid[0] = inject_reg;
    assign link_found[0] = 1'b0;
    assign link_idx[0]   = '0;
    assign link_size[0]  = '0;
    assign link_left[0]  = '0;

    for (genvar k = 0; k < MAX_PARTITIONS; k++) begin : g_cell
        logic load_hit;
        logic grant_hit;

        assign load_hit  = cmd.load && (int'(s_data.slot_index) == k);
        assign grant_hit = cmd.grant && (int'(link_idx[MAX_PARTITIONS]) == k);

        fpfa_cell #(
            .CELL_IDX  (k),
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .cmd            (cmd),
            .load_hit       (load_hit),
            .grant_hit      (grant_hit),
            .wr_size        (wr_size),
            .req_size       (req_reg),
            .policy         (policy_reg),
            .blocks_in_use  (blocks_reg),
            .rin_valid      (link_valid[k]),
            .rin_found      (link_found[k]),
            .rin_idx        (link_idx[k]),
            .rin_size       (link_size[k]),
            .rin_left       (link_left[k]),
            .rout_valid_reg (link_valid[k+1]),
            .rout_found_reg (link_found[k+1]),
            .rout_idx_reg   (link_idx[k+1]),
            .rout_size_reg  (link_size[k+1]),
            .rout_left_reg  (link_left[k+1])
        );
    end

    // Control sequencing and the output register.
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        owner_next   = owner_reg;
        inject_next  = 1'b0;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    if ((s_data.mode == MODE_ALLOC) && (s_data.owner_id != 8'd0)) begin
                        req_next    = in_size;
                        owner_next  = s_data.owner_id;
                        inject_next = 1'b1;
                        state_next  = ST_SCAN;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    res_next = '0;
                    if (link_found[MAX_PARTITIONS]) begin
                        res_next.granted      = 1'b1;
                        res_next.block_number =
                            5'({1'b0, link_idx[MAX_PARTITIONS]} + (IDX_W+1)'(1));
                        res_next.space_left   = 16'(link_left[MAX_PARTITIONS]);
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inject_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            policy_reg  <= POL_FIRST;
            blocks_reg  <= 5'd0;
        end else begin
            state_reg   <= state_next;
            inject_reg  <= inject_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FIT_POLICY) begin
                    policy_reg <= cfg_data[1:0];
                end else if (cfg_index == REG_BLOCKS_IN_USE) begin
                    blocks_reg <= cfg_data[4:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        owner_reg  <= owner_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hdl/fpfa_checker.sv =====
// ----------------------------------------------------------------------------
// Partition allocator checker
// Port-level assertions on the allocator core, attached by a bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpfa_checker import fpfa_pkg::*; #(
    parameter int MAX_PARTITIONS = 16
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result holds its value.
    `FPFA_ASSERT_CLK(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))

    // A refusal or a non-allocate result carries no partition.
    `FPFA_ASSERT_CLK(a_refuse_zero,
        (m_valid && !m_data.granted) |-> (m_data.block_number == 5'd0 && m_data.space_left == 16'd0))

    // A grant names a real partition.
    `FPFA_ASSERT_CLK(a_grant_range,
        (m_valid && m_data.granted) |->
            (m_data.block_number != 5'd0 && int'(m_data.block_number) <= MAX_PARTITIONS))

    // No new item is taken in the cycle after one was accepted.
    `FPFA_ASSERT_CLK(a_one_at_a_time, (s_valid && s_ready) |=> !s_ready)

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
) u_fpfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
